// ===== rtl/mble_pkg.sv =====
// Shared types, constants and mask helpers for the bitmap line engine.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package mble_pkg;

	localparam int MEM_BYTES    = 16384;
	localparam int MEM_AW       = $clog2(MEM_BYTES);
	localparam int ROW_BYTES    = 80;
	localparam int BITMAP_BYTES = 16000;
	localparam int CNT_W        = MEM_AW + 1;

	localparam logic [MEM_AW-1:0] ROW_STEP  = MEM_AW'(ROW_BYTES);
	localparam logic [MEM_AW-1:0] LAST_ADDR = MEM_AW'(MEM_BYTES - 1);
	localparam logic [CNT_W-1:0]  FILL_CNT  = CNT_W'(BITMAP_BYTES);

	typedef enum logic [1:0] {
		MODE_HSPAN = 2'd0,
		MODE_VSPAN = 2'd1,
		MODE_FILL  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// One memory access in flight between read issue and write back
	typedef struct packed {
		logic              valid;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        mask;
	} rmw_t;

	// Pixels from bit position pos to the right end of the byte
	function automatic logic [7:0] first_mask(input logic [2:0] pos);
		first_mask = 8'hFF >> pos;
	endfunction

	// Pixels from the left end of the byte up to bit position pos
	function automatic logic [7:0] last_mask(input logic [2:0] pos);
		last_mask = 8'hFF << (3'd7 - pos);
	endfunction

	function automatic logic [7:0] pixel_mask(input logic [2:0] pos);
		pixel_mask = 8'h80 >> pos;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mble_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mble_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mono_bitmap_line_engine_core.sv =====
// Bitmap line engine top level: command sequencer around one video memory.
// Depends on mble_pkg and mble_ram.
`timescale 1ns / 1ps
`default_nettype none

// Draws into a 640x200 one-bit-per-pixel bitmap held in a 16K x 8 video memory
// at byte offset display_base (addresses wrap at 16K). One command is worked at
// a time as a walk over the memory (read-modify-write for spans, write-only for
// fills), one byte per cycle through its single read and single write port. Each
// command gives one result transaction (read_data is zero except for reads); a
// result left waiting at the output lets the next command be accepted and worked,
// but holds that command in its last step until the waiting result is taken.
// After reset a clearing pass writes zero to all 16384 bytes, one per cycle,
// before the first command is taken; display_base may be written throughout.
module mono_bitmap_line_engine_core
	import mble_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [13:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [9:0]  x,
	input  wire logic [7:0]  y,
	input  wire logic [9:0]  length,
	input  wire logic        set_pixels,
	input  wire logic [7:0]  fill_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  read_data
);

	state_t state_q, state_d;

	logic [MEM_AW-1:0] base_q;
	logic [MEM_AW-1:0] clr_addr_q;

	mode_t             op_q;
	logic              set_q;
	logic [7:0]        fb_q;
	logic [7:0]        fm_q;
	logic [7:0]        lm_q;
	logic [MEM_AW-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              first_q;
	rmw_t              s1_q;
	logic [7:0]        res_q;
	logic              out_valid_q;
	logic [7:0]        rd_q;

	logic              accept;
	logic              issue;
	logic              out_load;

	logic [10:0]       last_px;
	logic [8:0]        h_bytes;
	logic [MEM_AW-1:0] start_addr;
	logic [CNT_W-1:0]  start_cnt;
	logic [MEM_AW-1:0] step;
	logic [7:0]        mask;

	logic              ram_we;
	logic [MEM_AW-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign read_data = rd_q;
	assign accept    = in_valid & in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (cnt_q <= CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_WALK:  issue    = (cnt_q != '0);
			ST_DONE:  out_load = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	// Command setup
	always_comb begin
		last_px    = {1'b0, x} + {1'b0, length} - 11'd1;
		h_bytes    = {1'b0, last_px[10:3]} - {2'b0, x[9:3]} + 9'd1;
		start_addr = base_q + ({6'b0, y} * ROW_STEP) + {7'b0, x[9:3]};
		unique case (mode_t'(mode))
			MODE_HSPAN: start_cnt = (length == '0) ? '0 : CNT_W'(h_bytes);
			MODE_VSPAN: start_cnt = CNT_W'(length);
			MODE_FILL:  start_cnt = FILL_CNT;
			MODE_READ:  start_cnt = CNT_W'(1);
			default:    start_cnt = '0;
		endcase
	end

	// Per-byte mask and address step of the walk
	always_comb begin
		unique case (op_q)
			MODE_HSPAN: begin
				mask = (first_q ? fm_q : 8'hFF) & ((cnt_q == CNT_W'(1)) ? lm_q : 8'hFF);
				step = MEM_AW'(1);
			end
			MODE_VSPAN: begin
				mask = fm_q;
				step = ROW_STEP;
			end
			MODE_FILL: begin
				mask = 8'hFF;
				step = MEM_AW'(1);
			end
			MODE_READ: begin
				mask = 8'h00;
				step = '0;
			end
			default: begin
				mask = 8'h00;
				step = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			base_q      <= '0;
			s1_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + MEM_AW'(1);
			end
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			s1_q.valid <= issue;
			s1_q.addr  <= addr_q;
			s1_q.mask  <= mask;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= mode_t'(mode);
			set_q   <= set_pixels;
			fb_q    <= fill_byte;
			fm_q    <= (mode_t'(mode) == MODE_VSPAN) ? pixel_mask(x[2:0]) : first_mask(x[2:0]);
			lm_q    <= last_mask(last_px[2:0]);
			addr_q  <= (mode_t'(mode) == MODE_FILL) ? base_q : start_addr;
			cnt_q   <= start_cnt;
			first_q <= 1'b1;
		end else if (issue) begin
			addr_q  <= addr_q + step;
			cnt_q   <= cnt_q - CNT_W'(1);
			first_q <= 1'b0;
		end
		// Hold the read byte until the output register is free
		if (state_q == ST_DRAIN) begin
			res_q <= (op_q == MODE_READ) ? ram_rdata : 8'h00;
		end
		if (out_load) begin
			rd_q <= res_q;
		end
	end

	// Memory port steering: clearing pass, else write back of the byte in flight
	always_comb begin
		ram_re = issue && (op_q != MODE_FILL);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 8'h00;
		end else begin
			ram_we    = s1_q.valid && (op_q != MODE_READ);
			ram_waddr = s1_q.addr;
			if (op_q == MODE_FILL) begin
				ram_wdata = fb_q;
			end else if (set_q) begin
				ram_wdata = ram_rdata | s1_q.mask;
			end else begin
				ram_wdata = ram_rdata & ~s1_q.mask;
			end
		end
	end

	mble_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_vram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

endmodule

`default_nettype wire
